FILE: sv/rufd_pkg.sv
// Package for the frame deframer: store geometry, header bytes, event codes,
// controller states and the command/status structs. No dependencies.
package rufd_pkg;
	localparam int STORE_DEPTH = 1024;
	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = AW + 1;
	localparam logic [7:0] HEAD_REPORT = 8'h5A;
	localparam logic [7:0] HEAD_REPLY = 8'h59;

	typedef enum logic [2:0] {
		EV_NONE = 3'd0,
		EV_STRAY = 3'd1,
		EV_BADCK = 3'd2,
		EV_REPORT = 3'd3,
		EV_REPLY = 3'd4,
		EV_FLUSH = 3'd5
	} event_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD0,
		ST_HEAD,
		ST_LEN,
		ST_LCAP,
		ST_BODY,
		ST_SRD,
		ST_SACC,
		ST_CK1,
		ST_CKRD,
		ST_CK2,
		ST_DRD,
		ST_DATA
	} state_t;

	typedef enum logic [2:0] {
		RD_HEAD,
		RD_LEN,
		RD_SUM,
		RD_CK,
		RD_DATA
	} rdsel_t;

	typedef struct packed {
		logic push;
		logic rd_en;
		rdsel_t rd_sel;
		logic cap_head;
		logic cap_len;
		logic sum_clr;
		logic sum_add;
		logic cap_ck1;
		logic start_deliver;
		logic step_deliver;
		logic consume1;
		logic consume3;
		event_t ev;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic delivering;
		logic kind;
		logic [7:0] head;
		logic avail_hdr;
		logic avail_body;
		logic sum_done;
		logic ck_ok;
		logic len_zero;
	} sts_t;
endpackage

FILE: sv/rufd_datapath.sv
// Datapath: byte store, pointers, checksum accumulator, delivery counter and
// output register. Depends on rufd_pkg.
module rufd_datapath import rufd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	input logic [7:0] rx_byte,
	output sts_t sts,
	output logic [2:0] event_res,
	output logic [7:0] data_byte,
	output logic last,
	output logic [8:0] frame_length
);
	logic [7:0] mem [STORE_DEPTH];
	logic [7:0] rd_q;
	logic [AW-1:0] rp_q;
	logic [CW-1:0] fill_q;
	logic deliv_q, kind_q;
	logic [8:0] rem_q, flen_q;
	logic [7:0] head_q, len_q, ck1_q;
	logic [15:0] sum_q;
	logic [8:0] k_q;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [8:0] rd_off, cnt, total;
	logic [CW-1:0] need;

	assign cnt = (head_q == HEAD_REPORT) ? {1'b0, len_q} + 9'd2 : {1'b0, len_q} + 9'd3;
	assign total = cnt + ((head_q == HEAD_REPORT) ? 9'd1 : 9'd2);
	assign need = CW'(total);

	always_comb begin
		unique case (cmd.rd_sel)
			RD_HEAD: rd_off = 9'd0;
			RD_LEN: rd_off = (head_q == HEAD_REPORT) ? 9'd1 : 9'd2;
			RD_SUM: rd_off = k_q;
			RD_CK: rd_off = k_q;
			RD_DATA: rd_off = ((kind_q) ? 9'd1 : 9'd2) + (flen_q - rem_q);
			default: rd_off = 9'd0;
		endcase
	end
	assign rd_addr = rp_q + AW'(rd_off);
	assign wr_addr = cmd.push && fill_q == CW'(STORE_DEPTH) ? '0 : rp_q + fill_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.push) mem[wr_addr] <= rx_byte;
		if (cmd.rd_en) rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= '0;
			fill_q <= '0;
			deliv_q <= 1'b0;
			kind_q <= 1'b0;
			rem_q <= '0;
		end else begin
			if (cmd.push) begin
				if (fill_q == CW'(STORE_DEPTH)) begin
					rp_q <= '0;
					fill_q <= CW'(1);
					deliv_q <= 1'b0;
					rem_q <= '0;
				end else begin
					fill_q <= fill_q + CW'(1);
				end
			end
			if (cmd.consume1) begin
				rp_q <= rp_q + AW'(1);
				fill_q <= fill_q - CW'(1);
			end
			if (cmd.consume3) begin
				rp_q <= rp_q + AW'(3);
				fill_q <= fill_q - CW'(3);
			end
			if (cmd.start_deliver) begin
				deliv_q <= 1'b1;
				kind_q <= (head_q == HEAD_REPLY);
				rem_q <= (head_q == HEAD_REPLY) ? {1'b0, len_q} + 9'd2 : {1'b0, len_q};
			end
			if (cmd.step_deliver) begin
				rem_q <= rem_q - 9'd1;
				if (rem_q == 9'd1) begin
					deliv_q <= 1'b0;
					rp_q <= rp_q + AW'(flen_q + 9'd3);
					fill_q <= fill_q - CW'(flen_q + 9'd3);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_head) head_q <= rd_q;
		if (cmd.cap_len) begin
			len_q <= rd_q;
		end
		if (cmd.start_deliver)
			flen_q <= (head_q == HEAD_REPLY) ? {1'b0, len_q} + 9'd2 : {1'b0, len_q};
		if (cmd.sum_clr) begin
			sum_q <= '0;
			k_q <= '0;
		end else if (cmd.sum_add) begin
			sum_q <= sum_q + {8'd0, rd_q};
			k_q <= k_q + 9'd1;
		end
		if (cmd.cap_ck1) begin
			ck1_q <= rd_q;
			k_q <= k_q + 9'd1;
		end
		if (cmd.out_load) begin
			event_res <= cmd.ev;
			unique case (cmd.ev)
				EV_STRAY, EV_BADCK: data_byte <= head_q;
				EV_FLUSH: data_byte <= rx_byte;
				EV_REPORT, EV_REPLY: data_byte <= cmd.step_deliver ? rd_q : 8'd0;
				default: data_byte <= 8'd0;
			endcase
			last <= (cmd.ev == EV_REPORT || cmd.ev == EV_REPLY) &&
				(!cmd.step_deliver || rem_q == 9'd1);
			frame_length <= (cmd.ev == EV_REPORT || cmd.ev == EV_REPLY) ?
				(cmd.step_deliver ? flen_q : 9'd0) : 9'd0;
		end
	end

	assign sts.empty = fill_q == '0;
	assign sts.full = fill_q == CW'(STORE_DEPTH);
	assign sts.delivering = deliv_q;
	assign sts.kind = kind_q;
	assign sts.head = head_q;
	assign sts.avail_hdr = fill_q >= ((head_q == HEAD_REPORT) ? CW'(2) : CW'(3));
	assign sts.avail_body = fill_q >= need;
	assign sts.sum_done = k_q == cnt;
	assign sts.ck_ok = (head_q == HEAD_REPORT) ? (sum_q[7:0] == rd_q) :
		(sum_q == {rd_q, ck1_q});
	assign sts.len_zero = len_q == 8'd0;

	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(STORE_DEPTH));
	a_push_alone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !(cmd.consume1 || cmd.consume3 || cmd.step_deliver));
endmodule

FILE: sv/rufd_ctrl.sv
// Controller state machine: sequences header reads, the checksum walk and
// delivery. Depends on rufd_pkg.
module rufd_ctrl import rufd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic action,
	output logic out_valid,
	input logic out_stall,
	input sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_d;
	logic ov_q, ov_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q <= ov_d;
		end
	end

	assign out_valid = ov_q;
	assign in_stall = state_q != ST_IDLE || ov_q;

	always_comb begin
		state_d = state_q;
		ov_d = ov_q && out_stall;
		cmd = '0;
		cmd.rd_sel = RD_HEAD;
		cmd.ev = EV_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && !ov_q) begin
					if (!action) begin
						cmd.push = 1'b1;
						if (sts.full) begin
							cmd.ev = EV_FLUSH;
							cmd.out_load = 1'b1;
							ov_d = 1'b1;
						end
					end else if (sts.delivering) begin
						state_d = ST_DRD;
					end else if (sts.empty) begin
						cmd.out_load = 1'b1;
						ov_d = 1'b1;
					end else begin
						state_d = ST_RD0;
					end
				end
			end
			ST_RD0: begin
				cmd.rd_en = 1'b1;
				state_d = ST_HEAD;
			end
			ST_HEAD: begin
				cmd.cap_head = 1'b1;
				state_d = ST_LEN;
			end
			ST_LEN: begin
				if (sts.head != HEAD_REPORT && sts.head != HEAD_REPLY) begin
					cmd.consume1 = 1'b1;
					cmd.ev = EV_STRAY;
					cmd.out_load = 1'b1;
					ov_d = 1'b1;
					state_d = ST_IDLE;
				end else if (!sts.avail_hdr) begin
					cmd.out_load = 1'b1;
					ov_d = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = RD_LEN;
					state_d = ST_LCAP;
				end
			end
			ST_LCAP: begin
				cmd.cap_len = 1'b1;
				state_d = ST_BODY;
			end
			ST_BODY: begin
				if (!sts.avail_body) begin
					cmd.out_load = 1'b1;
					ov_d = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cmd.sum_clr = 1'b1;
					state_d = ST_SRD;
				end
			end
			ST_SRD: begin
				cmd.rd_en = 1'b1;
				if (sts.sum_done) begin
					cmd.rd_sel = RD_CK;
					state_d = ST_CK1;
				end else begin
					cmd.rd_sel = RD_SUM;
					state_d = ST_SACC;
				end
			end
			ST_SACC: begin
				cmd.sum_add = 1'b1;
				state_d = ST_SRD;
			end
			ST_CK1: begin
				if (sts.head == HEAD_REPORT) begin
					if (!sts.ck_ok) begin
						cmd.consume1 = 1'b1;
						cmd.ev = EV_BADCK;
						cmd.out_load = 1'b1;
						ov_d = 1'b1;
						state_d = ST_IDLE;
					end else if (sts.len_zero) begin
						cmd.consume3 = 1'b1;
						cmd.ev = EV_REPORT;
						cmd.out_load = 1'b1;
						ov_d = 1'b1;
						state_d = ST_IDLE;
					end else begin
						cmd.start_deliver = 1'b1;
						state_d = ST_DRD;
					end
				end else begin
					cmd.cap_ck1 = 1'b1;
					state_d = ST_CKRD;
				end
			end
			ST_CKRD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_sel = RD_CK;
				state_d = ST_CK2;
			end
			ST_CK2: begin
				if (!sts.ck_ok) begin
					cmd.consume1 = 1'b1;
					cmd.ev = EV_BADCK;
					cmd.out_load = 1'b1;
					ov_d = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cmd.start_deliver = 1'b1;
					state_d = ST_DRD;
				end
			end
			ST_DRD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_sel = RD_DATA;
				state_d = ST_DATA;
			end
			ST_DATA: begin
				cmd.step_deliver = 1'b1;
				cmd.ev = sts.kind ? EV_REPLY : EV_REPORT;
				cmd.out_load = 1'b1;
				ov_d = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall);
	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid);
	a_busy_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !ov_q);
endmodule

FILE: sv/radar_uart_frame_deframer_core.sv
// Top level of the frame deframer: controller plus datapath. Depends on rufd_pkg.
// Results: flush, delivered byte, stray or short header, short body,
// first byte of a report or reply, bad checksum, empty report.
// The checksum walk reads each stored byte and adds it to the sum.
// One transaction at a time; input stalls while busy or while a result waits.
// Reset: asynchronous active-low arst_n clears pointers, fill, delivery and out_valid.
module radar_uart_frame_deframer_core import rufd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic action,
	input logic [7:0] rx_byte,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] event_res,
	output logic [7:0] data_byte,
	output logic last,
	output logic [8:0] frame_length
);
	cmd_t cmd;
	sts_t sts;

	rufd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.action(action), .out_valid(out_valid), .out_stall(out_stall),
		.sts(sts), .cmd(cmd)
	);

	rufd_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .rx_byte(rx_byte), .sts(sts),
		.event_res(event_res), .data_byte(data_byte), .last(last),
		.frame_length(frame_length)
	);
endmodule
